/* rtl/eddss_pkg.sv */
package eddss_pkg;

    // batch capacity and derived widths
    localparam int MAX_REQ  = 32;
    localparam int CNT_W    = $clog2(MAX_REQ + 1);
    localparam int IDX_W    = $clog2(MAX_REQ);
    localparam int CYL_W    = 16;
    localparam int MOVE_W   = 18;
    localparam int CCNT_W   = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    // cylinder count clamp limits and reset values
    localparam logic [CCNT_W-1:0] CCNT_MIN   = 17'd2;
    localparam logic [CCNT_W-1:0] CCNT_MAX   = 17'd65536;
    localparam logic [CCNT_W-1:0] CCNT_RESET = 17'd200;

    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [CYL_W-1:0]  t_cyl;
    typedef logic [MOVE_W-1:0] t_move;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CIRCULAR   = 2'd0,
        CFG_SWEEP_UP   = 2'd1,
        CFG_START_HEAD = 2'd2,
        CFG_CYL_COUNT  = 2'd3
    } t_cfg_idx;

    // input and output beats
    typedef struct packed {
        logic [CYL_W-1:0] cylinder;
        logic             is_last;
    } t_in_item;

    typedef struct packed {
        logic              kind;
        logic [CYL_W-1:0]  served_cylinder;
        logic [MOVE_W-1:0] movement;
        logic              overflow;
        logic              last;
    } t_out_item;

    // index range endpoints
    typedef enum logic [1:0] {
        JS_ZERO,
        JS_I,
        JS_N
    } t_jsel;

    // head move targets
    typedef enum logic [1:0] {
        TG_REQ,
        TG_TOP,
        TG_ZERO
    } t_tgt;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FIND_INIT,
        ST_FIND,
        ST_A_INIT,
        ST_A_MEAS,
        ST_A_APPLY,
        ST_EDGE_MEAS,
        ST_EDGE_APPLY,
        ST_WRAP,
        ST_B_INIT,
        ST_B_MEAS,
        ST_B_APPLY,
        ST_SUM
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic  load;
        logic  range_start;
        t_jsel range_src;
        t_jsel range_end;
        logic  range_asc;
        logic  j_step;
        logic  latch_i;
        logic  meas;
        t_tgt  meas_tgt;
        logic  apply;
        logic  emit_req;
        logic  wrap;
        logic  emit_sum;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic range_done;
        logic find_hit;
        logic out_free;
        logic sweep_up;
        logic circular;
    } t_dp_stat;

endpackage

/* rtl/elevator_disk_seek_scheduler_unit.sv */
// loading: one request beat per cycle while the sequencer is idle, into an insertion-sorted row of cells
// after the last request: a search for the split point s, then for each sweep a set-up step,
// a measure and an apply step per served request and a closing measure; the edge travel
// comes after the first sweep and, in circular mode, the wrap jump before the second
// output stalls hold the apply and summary steps until the output register is free
// synchronous active-low reset clears batch, config to defaults, output empty
module elevator_disk_seek_scheduler_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [eddss_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [eddss_pkg::CFG_DATA_W-1:0]    i_cfg_wr_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  eddss_pkg::t_in_item                 i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output eddss_pkg::t_out_item                o_out_data
);

    eddss_pkg::t_dp_cmd  w_cmd;
    eddss_pkg::t_dp_stat w_stat;

    // sequencer
    eddss_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_is_last (i_in_data.is_last),
        .i_stat       (w_stat),
        .o_in_stall   (o_in_stall),
        .o_cmd        (w_cmd)
    );

    // request store, head tracking and output register
    eddss_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_data     (i_in_data),
        .i_out_stall   (i_out_stall),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .o_out_valid   (o_out_valid),
        .o_out_data    (o_out_data)
    );

    // a beat is never loaded over one that is still stalled
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.emit_req || w_cmd.emit_sum) |-> w_stat.out_free)
        else $error("output beat overwritten while stalled");

    // the summary beat is the only one marked last
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.kind == o_out_data.last))
        else $error("last flag disagrees with beat kind");

    // requests are loaded only while the sequencer is idle
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load |-> !(w_cmd.apply || w_cmd.emit_req || w_cmd.emit_sum))
        else $error("request loaded during scheduling");

    // output is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("output valid after reset");

endmodule

/* rtl/eddss_sorter.sv */
module eddss_sorter (
    input  logic              i_clk,
    input  logic              i_ins_en,
    input  eddss_pkg::t_cyl   i_ins_value,
    input  eddss_pkg::t_cnt   i_count,
    input  eddss_pkg::t_idx   i_rd_addr,
    output eddss_pkg::t_cyl   o_rd_data
);

    eddss_pkg::t_cyl r_cell [eddss_pkg::MAX_REQ];
    eddss_pkg::t_cyl n_cell [eddss_pkg::MAX_REQ];
    logic [eddss_pkg::MAX_REQ-1:0] w_gt;

    // each cell compares against the new value; empty cells count as larger
    always_comb begin
        for (int c = 0; c < eddss_pkg::MAX_REQ; c++) begin
            w_gt[c] = (eddss_pkg::t_cnt'(c) >= i_count) || (r_cell[c] > i_ins_value);
        end
    end

    // insertion point takes the new value, cells above it shift up by one
    always_comb begin
        n_cell[0] = w_gt[0] ? i_ins_value : r_cell[0];
        for (int c = 1; c < eddss_pkg::MAX_REQ; c++) begin
            if (!w_gt[c]) begin
                n_cell[c] = r_cell[c];
            end else if (!w_gt[c-1]) begin
                n_cell[c] = i_ins_value;
            end else begin
                n_cell[c] = r_cell[c-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ins_en) begin
            r_cell <= n_cell;
        end
    end

    assign o_rd_data = r_cell[i_rd_addr];

endmodule

/* rtl/eddss_dpath.sv */
module eddss_dpath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [eddss_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [eddss_pkg::CFG_DATA_W-1:0]    i_cfg_wr_data,
    input  eddss_pkg::t_in_item                 i_in_data,
    input  logic                                i_out_stall,
    input  eddss_pkg::t_dp_cmd                  i_cmd,
    output eddss_pkg::t_dp_stat                 o_stat,
    output logic                                o_out_valid,
    output eddss_pkg::t_out_item                o_out_data
);

    // configuration
    logic                               r_circular,   n_circular;
    logic                               r_sweep_up,   n_sweep_up;
    eddss_pkg::t_cyl                    r_start_head, n_start_head;
    logic [eddss_pkg::CCNT_W-1:0]       r_cyl_count,  n_cyl_count;

    // batch and schedule state
    eddss_pkg::t_cnt      r_count,   n_count;
    logic                 r_dropped, n_dropped;
    eddss_pkg::t_cyl      r_head,    n_head;
    eddss_pkg::t_move     r_move,    n_move;
    eddss_pkg::t_cnt      r_j,       n_j;
    eddss_pkg::t_cnt      r_end,     n_end;
    logic                 r_asc,     n_asc;
    eddss_pkg::t_cnt      r_i,       n_i;
    eddss_pkg::t_cyl      r_dist,    n_dist;
    eddss_pkg::t_cyl      r_target,  n_target;
    eddss_pkg::t_out_item r_out,     n_out;
    logic                 r_out_valid, n_out_valid;

    logic                 w_ins_en;
    eddss_pkg::t_idx      w_rd_addr;
    eddss_pkg::t_cyl      w_rd_data;
    eddss_pkg::t_cyl      w_top;
    eddss_pkg::t_cyl      w_meas_tgt;
    eddss_pkg::t_cyl      w_addend;
    logic [eddss_pkg::MOVE_W:0] w_sum;
    eddss_pkg::t_move     w_move_sat;
    logic                 w_out_free;

    // sorted request cells
    assign w_ins_en  = i_cmd.load && (r_count < eddss_pkg::t_cnt'(eddss_pkg::MAX_REQ));
    assign w_rd_addr = r_asc ? r_j[eddss_pkg::IDX_W-1:0] : eddss_pkg::t_idx'(r_j - 1'b1);

    eddss_sorter u_sorter (
        .i_clk       (i_clk),
        .i_ins_en    (w_ins_en),
        .i_ins_value (i_in_data.cylinder),
        .i_count     (r_count),
        .i_rd_addr   (w_rd_addr),
        .o_rd_data   (w_rd_data)
    );

    // top edge from the clamped cylinder count
    always_comb begin
        if (r_cyl_count < eddss_pkg::CCNT_MIN) begin
            w_top = eddss_pkg::t_cyl'(eddss_pkg::CCNT_MIN - 1'b1);
        end else if (r_cyl_count > eddss_pkg::CCNT_MAX) begin
            w_top = eddss_pkg::t_cyl'(eddss_pkg::CCNT_MAX - 1'b1);
        end else begin
            w_top = eddss_pkg::t_cyl'(r_cyl_count - 1'b1);
        end
    end

    // move target select
    always_comb begin
        unique case (i_cmd.meas_tgt)
            eddss_pkg::TG_REQ:  w_meas_tgt = w_rd_data;
            eddss_pkg::TG_TOP:  w_meas_tgt = w_top;
            eddss_pkg::TG_ZERO: w_meas_tgt = '0;
            default:            w_meas_tgt = '0;
        endcase
    end

    // saturating movement adder shared by head moves and the wrap jump
    assign w_addend   = i_cmd.wrap ? w_top : r_dist;
    assign w_sum      = {1'b0, r_move} + {{(eddss_pkg::MOVE_W + 1 - eddss_pkg::CYL_W){1'b0}},
                        w_addend};
    assign w_move_sat = w_sum[eddss_pkg::MOVE_W] ? '1 : w_sum[eddss_pkg::MOVE_W-1:0];

    assign w_out_free = !r_out_valid || !i_out_stall;

    // configuration writes
    always_comb begin
        n_circular   = r_circular;
        n_sweep_up   = r_sweep_up;
        n_start_head = r_start_head;
        n_cyl_count  = r_cyl_count;
        if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                eddss_pkg::CFG_CIRCULAR:   n_circular   = i_cfg_wr_data[0];
                eddss_pkg::CFG_SWEEP_UP:   n_sweep_up   = i_cfg_wr_data[0];
                eddss_pkg::CFG_START_HEAD: n_start_head = i_cfg_wr_data[eddss_pkg::CYL_W-1:0];
                eddss_pkg::CFG_CYL_COUNT:  n_cyl_count  = i_cfg_wr_data[eddss_pkg::CCNT_W-1:0];
                default: ;
            endcase
        end
    end

    // batch loading, index walk and head moves
    always_comb begin
        n_count     = r_count;
        n_dropped   = r_dropped;
        n_head      = r_head;
        n_move      = r_move;
        n_j         = r_j;
        n_end       = r_end;
        n_asc       = r_asc;
        n_i         = r_i;
        n_dist      = r_dist;
        n_target    = r_target;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;

        if (i_cmd.load) begin
            if (w_ins_en) begin
                n_count = eddss_pkg::t_cnt'(r_count + 1'b1);
            end else begin
                n_dropped = 1'b1;
            end
            if (i_in_data.is_last) begin
                n_head = r_start_head;
                n_move = '0;
            end
        end

        if (i_cmd.range_start) begin
            unique case (i_cmd.range_src)
                eddss_pkg::JS_ZERO: n_j = '0;
                eddss_pkg::JS_I:    n_j = r_i;
                eddss_pkg::JS_N:    n_j = r_count;
                default:            n_j = '0;
            endcase
            unique case (i_cmd.range_end)
                eddss_pkg::JS_ZERO: n_end = '0;
                eddss_pkg::JS_I:    n_end = r_i;
                eddss_pkg::JS_N:    n_end = r_count;
                default:            n_end = '0;
            endcase
            n_asc = i_cmd.range_asc;
        end

        if (i_cmd.j_step) begin
            n_j = r_asc ? eddss_pkg::t_cnt'(r_j + 1'b1) : eddss_pkg::t_cnt'(r_j - 1'b1);
        end

        if (i_cmd.latch_i) begin
            n_i = r_j;
        end

        // distance to the next target
        if (i_cmd.meas) begin
            n_target = w_meas_tgt;
            n_dist   = (r_head > w_meas_tgt) ? r_head - w_meas_tgt : w_meas_tgt - r_head;
        end

        if (i_cmd.apply) begin
            n_move = w_move_sat;
            n_head = r_target;
        end

        if (i_cmd.wrap) begin
            n_move = w_move_sat;
            n_head = r_sweep_up ? '0 : w_top;
        end

        // served beat
        if (i_cmd.emit_req) begin
            n_out.kind            = 1'b0;
            n_out.served_cylinder = r_target;
            n_out.movement        = w_move_sat;
            n_out.overflow        = r_dropped;
            n_out.last            = 1'b0;
            n_out_valid           = 1'b1;
        end

        // summary beat ends the batch
        if (i_cmd.emit_sum) begin
            n_out.kind            = 1'b1;
            n_out.served_cylinder = '0;
            n_out.movement        = r_move;
            n_out.overflow        = r_dropped;
            n_out.last            = 1'b1;
            n_out_valid           = 1'b1;
            n_count               = '0;
            n_dropped             = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_circular   <= 1'b0;
            r_sweep_up   <= 1'b1;
            r_start_head <= '0;
            r_cyl_count  <= eddss_pkg::CCNT_RESET;
            r_count      <= '0;
            r_dropped    <= 1'b0;
            r_head       <= '0;
            r_move       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_circular   <= n_circular;
            r_sweep_up   <= n_sweep_up;
            r_start_head <= n_start_head;
            r_cyl_count  <= n_cyl_count;
            r_count      <= n_count;
            r_dropped    <= n_dropped;
            r_head       <= n_head;
            r_move       <= n_move;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_j      <= n_j;
        r_end    <= n_end;
        r_asc    <= n_asc;
        r_i      <= n_i;
        r_dist   <= n_dist;
        r_target <= n_target;
        r_out    <= n_out;
    end

    // status back to the controller
    always_comb begin
        o_stat.range_done = (r_j == r_end);
        o_stat.find_hit   = (r_j == r_end) || (w_rd_data >= r_start_head);
        o_stat.out_free   = w_out_free;
        o_stat.sweep_up   = r_sweep_up;
        o_stat.circular   = r_circular;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

/* rtl/eddss_ctrl.sv */
module eddss_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_is_last,
    input  eddss_pkg::t_dp_stat  i_stat,
    output logic                 o_in_stall,
    output eddss_pkg::t_dp_cmd   o_cmd
);

    eddss_pkg::t_state r_state, n_state;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            eddss_pkg::ST_IDLE: begin
                if (i_in_valid && i_in_is_last) begin
                    n_state = eddss_pkg::ST_FIND_INIT;
                end
            end
            eddss_pkg::ST_FIND_INIT: n_state = eddss_pkg::ST_FIND;
            eddss_pkg::ST_FIND: begin
                if (i_stat.find_hit) begin
                    n_state = eddss_pkg::ST_A_INIT;
                end
            end
            eddss_pkg::ST_A_INIT: n_state = eddss_pkg::ST_A_MEAS;
            eddss_pkg::ST_A_MEAS: begin
                n_state = i_stat.range_done ? eddss_pkg::ST_EDGE_MEAS : eddss_pkg::ST_A_APPLY;
            end
            eddss_pkg::ST_A_APPLY: begin
                if (i_stat.out_free) begin
                    n_state = eddss_pkg::ST_A_MEAS;
                end
            end
            eddss_pkg::ST_EDGE_MEAS: n_state = eddss_pkg::ST_EDGE_APPLY;
            eddss_pkg::ST_EDGE_APPLY: begin
                n_state = i_stat.circular ? eddss_pkg::ST_WRAP : eddss_pkg::ST_B_INIT;
            end
            eddss_pkg::ST_WRAP:   n_state = eddss_pkg::ST_B_INIT;
            eddss_pkg::ST_B_INIT: n_state = eddss_pkg::ST_B_MEAS;
            eddss_pkg::ST_B_MEAS: begin
                n_state = i_stat.range_done ? eddss_pkg::ST_SUM : eddss_pkg::ST_B_APPLY;
            end
            eddss_pkg::ST_B_APPLY: begin
                if (i_stat.out_free) begin
                    n_state = eddss_pkg::ST_B_MEAS;
                end
            end
            eddss_pkg::ST_SUM: begin
                if (i_stat.out_free) begin
                    n_state = eddss_pkg::ST_IDLE;
                end
            end
            default: n_state = eddss_pkg::ST_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        o_cmd           = '0;
        o_cmd.range_src = eddss_pkg::JS_ZERO;
        o_cmd.range_end = eddss_pkg::JS_ZERO;
        o_cmd.meas_tgt  = eddss_pkg::TG_REQ;
        o_in_stall      = (r_state != eddss_pkg::ST_IDLE);
        unique case (r_state)
            eddss_pkg::ST_IDLE: begin
                o_cmd.load = i_in_valid;
            end
            // search for the first request at or above the start head
            eddss_pkg::ST_FIND_INIT: begin
                o_cmd.range_start = 1'b1;
                o_cmd.range_src   = eddss_pkg::JS_ZERO;
                o_cmd.range_end   = eddss_pkg::JS_N;
                o_cmd.range_asc   = 1'b1;
            end
            eddss_pkg::ST_FIND: begin
                o_cmd.latch_i = i_stat.find_hit;
                o_cmd.j_step  = !i_stat.find_hit;
            end
            // first sweep toward the chosen edge
            eddss_pkg::ST_A_INIT: begin
                o_cmd.range_start = 1'b1;
                o_cmd.range_src   = eddss_pkg::JS_I;
                o_cmd.range_end   = i_stat.sweep_up ? eddss_pkg::JS_N : eddss_pkg::JS_ZERO;
                o_cmd.range_asc   = i_stat.sweep_up;
            end
            eddss_pkg::ST_A_MEAS, eddss_pkg::ST_B_MEAS: begin
                o_cmd.meas     = !i_stat.range_done;
                o_cmd.meas_tgt = eddss_pkg::TG_REQ;
            end
            eddss_pkg::ST_A_APPLY, eddss_pkg::ST_B_APPLY: begin
                o_cmd.apply    = i_stat.out_free;
                o_cmd.emit_req = i_stat.out_free;
                o_cmd.j_step   = i_stat.out_free;
            end
            // travel to the edge
            eddss_pkg::ST_EDGE_MEAS: begin
                o_cmd.meas     = 1'b1;
                o_cmd.meas_tgt = i_stat.sweep_up ? eddss_pkg::TG_TOP : eddss_pkg::TG_ZERO;
            end
            eddss_pkg::ST_EDGE_APPLY: begin
                o_cmd.apply = 1'b1;
            end
            eddss_pkg::ST_WRAP: begin
                o_cmd.wrap = 1'b1;
            end
            // second sweep: same direction after a wrap, else reversed
            eddss_pkg::ST_B_INIT: begin
                o_cmd.range_start = 1'b1;
                if (i_stat.circular) begin
                    o_cmd.range_src = i_stat.sweep_up ? eddss_pkg::JS_ZERO : eddss_pkg::JS_N;
                    o_cmd.range_end = eddss_pkg::JS_I;
                    o_cmd.range_asc = i_stat.sweep_up;
                end else begin
                    o_cmd.range_src = eddss_pkg::JS_I;
                    o_cmd.range_end = i_stat.sweep_up ? eddss_pkg::JS_ZERO : eddss_pkg::JS_N;
                    o_cmd.range_asc = !i_stat.sweep_up;
                end
            end
            eddss_pkg::ST_SUM: begin
                o_cmd.emit_sum = i_stat.out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= eddss_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
